/* hw/rtl/pdm_pkg.sv */
package pdm_pkg;

    // image geometry default
    localparam int SIDE_DEFAULT = 1024;

    // field widths
    localparam int COORD_W    = 16;
    localparam int GAIN_XY_W  = 24;
    localparam int GAIN_Z_W   = 32;
    localparam int DEPTH_W    = 16;
    localparam int PIX_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_MAX_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_MIN_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Z     = 3'd7;

    // register reset values
    localparam logic signed [COORD_W-1:0] RST_CROP_MIN_X = -16'sd5000;
    localparam logic signed [COORD_W-1:0] RST_CROP_MAX_X = 16'sd5000;
    localparam logic signed [COORD_W-1:0] RST_CROP_MIN_Y = -16'sd5000;
    localparam logic signed [COORD_W-1:0] RST_CROP_MAX_Y = 16'sd5000;
    localparam logic signed [COORD_W-1:0] RST_CROP_MIN_Z = 16'sd0;
    localparam logic [GAIN_XY_W-1:0]      RST_GAIN_X     = 24'd6711;
    localparam logic [GAIN_XY_W-1:0]      RST_GAIN_Y     = 24'd6711;
    localparam logic [GAIN_Z_W-1:0]       RST_GAIN_Z     = 32'd429496;

    // signed 16-bit integer depth saturation limits
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7FFF;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;

    // configuration register set
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] min_z;
        logic [GAIN_XY_W-1:0]      gain_x;
        logic [GAIN_XY_W-1:0]      gain_y;
        logic [GAIN_Z_W-1:0]       gain_z;
    } t_cfg;

    // stage enables from the sequencer
    typedef struct packed {
        logic load;
        logic mul;
        logic rd;
    } t_stage_ctl;

    // projection result handed to write-back
    typedef struct packed {
        logic                      cmd;
        logic                      view;
        logic                      rd_ok;
        logic [PIX_W-1:0]          row;
        logic [PIX_W-1:0]          col;
        logic signed [DEPTH_W-1:0] depth;
    } t_proj_res;

endpackage

/* hw/rtl/pdm_depth_ram.sv */
module pdm_depth_ram
    import pdm_pkg::*;
#(
    parameter int IMAGE_SIDE = SIDE_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rd_en,
    input  logic [$clog2(IMAGE_SIDE*IMAGE_SIDE)-1:0] i_rd_addr,
    output logic signed [DEPTH_W-1:0]        o_rd_data,
    input  logic                             i_wr_en,
    input  logic [$clog2(IMAGE_SIDE*IMAGE_SIDE)-1:0] i_wr_addr,
    input  logic signed [DEPTH_W-1:0]        i_wr_data
);

    localparam int DEPTH = IMAGE_SIDE * IMAGE_SIDE;

    logic signed [DEPTH_W-1:0] r_mem [DEPTH];
    logic signed [DEPTH_W-1:0] r_q;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

/* hw/rtl/pdm_project.sv */
module pdm_project
    import pdm_pkg::*;
#(
    parameter int IMAGE_SIDE = SIDE_DEFAULT
) (
    input  logic                      i_clk,
    input  t_cfg                      i_cfg,
    input  t_stage_ctl                i_ctl,
    input  logic                      i_cmd,
    input  logic                      i_point_valid,
    input  logic signed [COORD_W-1:0] i_x_mm,
    input  logic signed [COORD_W-1:0] i_y_mm,
    input  logic signed [COORD_W-1:0] i_z_mm,
    input  logic [PIX_W-1:0]          i_read_row,
    input  logic [PIX_W-1:0]          i_read_col,
    output logic [$clog2(IMAGE_SIDE*IMAGE_SIDE)-1:0] o_rd_addr,
    output logic [$clog2(IMAGE_SIDE*IMAGE_SIDE)-1:0] o_wr_addr,
    output t_proj_res                 o_res
);

    localparam int IDX_W = $clog2(IMAGE_SIDE);
    localparam int AW    = $clog2(IMAGE_SIDE * IMAGE_SIDE);
    localparam int PX_W  = GAIN_XY_W + COORD_W;
    localparam int PZ_W  = GAIN_Z_W + COORD_W;

    // load stage: crop test and offsets
    logic                      in_crop;
    logic [COORD_W:0]          dx17, dy17, dz17, dz_mag17;

    logic                      r_cmd, r_inside, r_dz_neg;
    logic [COORD_W-1:0]        r_dx, r_dy, r_dz_mag;
    logic [PIX_W-1:0]          r_rrow, r_rcol;

    // multiply stage
    logic [PX_W-1:0]           r_px, r_py;
    logic [PZ_W-1:0]           r_pz;

    // address stage
    logic [GAIN_XY_W-1:0]      col_full, row_full;
    logic [GAIN_Z_W-1:0]       q;
    logic                      in_img, view, rd_ok;
    logic signed [DEPTH_W-1:0] d_sat;
    logic [31:0]               rrow32, rcol32;
    logic [IDX_W-1:0]          row_idx, col_idx;
    logic [AW-1:0]             addr;

    logic [AW-1:0]             r_addr;
    t_proj_res                 r_res;

    assign in_crop = i_point_valid &&
                     (i_x_mm >= i_cfg.min_x) && (i_x_mm <= i_cfg.max_x) &&
                     (i_y_mm >= i_cfg.min_y) && (i_y_mm <= i_cfg.max_y);

    assign dx17     = {i_x_mm[COORD_W-1], i_x_mm} - {i_cfg.min_x[COORD_W-1], i_cfg.min_x};
    assign dy17     = {i_y_mm[COORD_W-1], i_y_mm} - {i_cfg.min_y[COORD_W-1], i_cfg.min_y};
    assign dz17     = {i_z_mm[COORD_W-1], i_z_mm} - {i_cfg.min_z[COORD_W-1], i_cfg.min_z};
    assign dz_mag17 = dz17[COORD_W] ? ((COORD_W+1)'(0) - dz17) : dz17;

    // capture the transfer
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_inside <= in_crop;
            r_dx     <= dx17[COORD_W-1:0];
            r_dy     <= dy17[COORD_W-1:0];
            r_dz_neg <= dz17[COORD_W];
            r_dz_mag <= dz_mag17[COORD_W-1:0];
            r_rrow   <= i_read_row;
            r_rcol   <= i_read_col;
        end
    end

    // scale by the gains
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_px <= PX_W'(i_cfg.gain_x) * PX_W'(r_dx);
            r_py <= PX_W'(i_cfg.gain_y) * PX_W'(r_dy);
            r_pz <= PZ_W'(i_cfg.gain_z) * PZ_W'(r_dz_mag);
        end
    end

    // drop the fraction, range check, saturate depth
    assign col_full = r_px[PX_W-1:16];
    assign row_full = r_py[PX_W-1:16];
    assign q        = r_pz[PZ_W-1:16];
    assign in_img   = (col_full < GAIN_XY_W'(IMAGE_SIDE)) &&
                      (row_full < GAIN_XY_W'(IMAGE_SIDE));
    assign view     = !r_cmd && r_inside && in_img;

    always_comb begin
        if (r_dz_neg) begin
            d_sat = (q >= 32'd32768) ? DEPTH_MIN : (16'd0 - {1'b0, q[14:0]});
        end else begin
            d_sat = (q >= 32'd32767) ? DEPTH_MAX : q[DEPTH_W-1:0];
        end
    end

    // pixel address for either command
    assign rrow32 = 32'(r_rrow);
    assign rcol32 = 32'(r_rcol);
    assign rd_ok  = (rrow32 < IMAGE_SIDE) && (rcol32 < IMAGE_SIDE);

    always_comb begin
        if (r_cmd) begin
            row_idx = rrow32[IDX_W-1:0];
            col_idx = rcol32[IDX_W-1:0];
        end else begin
            row_idx = row_full[IDX_W-1:0];
            col_idx = col_full[IDX_W-1:0];
        end
    end

    assign addr = AW'(row_idx) * AW'(IMAGE_SIDE) + AW'(col_idx);

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_addr      <= addr;
            r_res.cmd   <= r_cmd;
            r_res.view  <= view;
            r_res.rd_ok <= rd_ok;
            if (r_cmd) begin
                r_res.row <= r_rrow;
                r_res.col <= r_rcol;
            end else if (view) begin
                r_res.row <= row_full[PIX_W-1:0];
                r_res.col <= col_full[PIX_W-1:0];
            end else begin
                r_res.row <= '0;
                r_res.col <= '0;
            end
            r_res.depth <= view ? d_sat : '0;
        end
    end

    assign o_rd_addr = addr;
    assign o_wr_addr = r_addr;
    assign o_res     = r_res;

endmodule

/* hw/rtl/point_to_depth_map_projector.sv */
// Point to depth map projector: a max-z buffer over a square depth image.
// Input channel (i_in_valid / o_in_stall) carries one command per transfer:
// insert a point (i_cmd low) or read one stored pixel (i_cmd high).
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// command, in order: in_view, updated, pixel row and column, and depth.
// Each command runs through a load, multiply, address/read and write-back
// step around the one-read one-write pixel store, one command at a time, so a
// new command is taken only once the last one has left write-back and its
// result is registered; the read-modify-write of the store sets this order.
// The output register frees the input side: a command may start while the
// previous result is still held. If the receiver stalls, the finished
// command waits in write-back and the input stalls until it drains.
// After reset the store is cleared to zero over all IMAGE_SIDE*IMAGE_SIDE
// pixels (1048576 at the default size) with the input stalled; the
// configuration registers return to their reset values at once and may be
// written at any time while no command is in flight.
module point_to_depth_map_projector
    import pdm_pkg::*;
#(
    parameter int IMAGE_SIDE = SIDE_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_cmd,
    input  logic                      i_point_valid,
    input  logic signed [COORD_W-1:0] i_x_mm,
    input  logic signed [COORD_W-1:0] i_y_mm,
    input  logic signed [COORD_W-1:0] i_z_mm,
    input  logic [PIX_W-1:0]          i_read_row,
    input  logic [PIX_W-1:0]          i_read_col,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_in_view,
    output logic                      o_updated,
    output logic [PIX_W-1:0]          o_pixel_row,
    output logic [PIX_W-1:0]          o_pixel_col,
    output logic signed [DEPTH_W-1:0] o_depth
);

    localparam int DEPTH = IMAGE_SIDE * IMAGE_SIDE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_WB    = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [AW-1:0]             r_clr, n_clr;
    t_cfg                      r_cfg;

    logic                      accept, out_free, wb_done, upd;
    t_stage_ctl                ctl;
    t_proj_res                 res;
    logic [AW-1:0]             rd_addr, res_addr, wr_addr;
    logic                      wr_en;
    logic signed [DEPTH_W-1:0] wr_data, rd_data, out_depth;

    logic                      r_out_valid;
    logic                      r_out_in_view, r_out_updated;
    logic [PIX_W-1:0]          r_out_row, r_out_col;
    logic signed [DEPTH_W-1:0] r_out_depth;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_x  <= RST_CROP_MIN_X;
            r_cfg.max_x  <= RST_CROP_MAX_X;
            r_cfg.min_y  <= RST_CROP_MIN_Y;
            r_cfg.max_y  <= RST_CROP_MAX_Y;
            r_cfg.min_z  <= RST_CROP_MIN_Z;
            r_cfg.gain_x <= RST_GAIN_X;
            r_cfg.gain_y <= RST_GAIN_Y;
            r_cfg.gain_z <= RST_GAIN_Z;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CROP_MIN_X: r_cfg.min_x  <= i_cfg_data[COORD_W-1:0];
                CFG_CROP_MAX_X: r_cfg.max_x  <= i_cfg_data[COORD_W-1:0];
                CFG_CROP_MIN_Y: r_cfg.min_y  <= i_cfg_data[COORD_W-1:0];
                CFG_CROP_MAX_Y: r_cfg.max_y  <= i_cfg_data[COORD_W-1:0];
                CFG_CROP_MIN_Z: r_cfg.min_z  <= i_cfg_data[COORD_W-1:0];
                CFG_GAIN_X:     r_cfg.gain_x <= i_cfg_data[GAIN_XY_W-1:0];
                CFG_GAIN_Y:     r_cfg.gain_y <= i_cfg_data[GAIN_XY_W-1:0];
                CFG_GAIN_Z:     r_cfg.gain_z <= i_cfg_data[GAIN_Z_W-1:0];
            endcase
        end
    end

    // handshake and stage enables
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign wb_done    = (r_state == ST_WB) && out_free;
    assign ctl.load   = accept;
    assign ctl.mul    = (r_state == ST_MUL);
    assign ctl.rd     = (r_state == ST_RD);

    // sequencer: clearing sweep, then one command at a time
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_RD;
            ST_RD:  n_state = ST_WB;
            ST_WB: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    pdm_project #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_project (
        .i_clk         (i_clk),
        .i_cfg         (r_cfg),
        .i_ctl         (ctl),
        .i_cmd         (i_cmd),
        .i_point_valid (i_point_valid),
        .i_x_mm        (i_x_mm),
        .i_y_mm        (i_y_mm),
        .i_z_mm        (i_z_mm),
        .i_read_row    (i_read_row),
        .i_read_col    (i_read_col),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (res_addr),
        .o_res         (res)
    );

    // write-back: keep the higher depth, or zero the store while clearing
    assign upd     = res.view && (res.depth > rd_data);
    assign wr_en   = (r_state == ST_CLEAR) || (wb_done && upd);
    assign wr_addr = (r_state == ST_CLEAR) ? r_clr : res_addr;
    assign wr_data = (r_state == ST_CLEAR) ? '0 : res.depth;

    pdm_depth_ram #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (ctl.rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // output register
    assign out_depth = res.cmd ? (res.rd_ok ? rd_data : '0) : res.depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_done) begin
            r_out_in_view <= res.view;
            r_out_updated <= upd;
            r_out_row     <= res.row;
            r_out_col     <= res.col;
            r_out_depth   <= out_depth;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_in_view   = r_out_in_view;
    assign o_updated   = r_out_updated;
    assign o_pixel_row = r_out_row;
    assign o_pixel_col = r_out_col;
    assign o_depth     = r_out_depth;

    // a transfer walks through multiply and read in consecutive cycles
    a_seq_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_MUL) ##1 (r_state == ST_RD) ##1 (r_state == ST_WB))
        else $error("command did not step through multiply and read");

    // a stalled write-back keeps its read data until it drains
    a_wb_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WB) && !out_free) |=> ((r_state == ST_WB) && $stable(rd_data)))
        else $error("write-back lost its read data while stalled");

    // a finished command always lands in the output register
    a_wb_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wb_done |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("write-back finished without a result");

    // only an in-view insert can raise a pixel
    a_upd_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_updated || r_out_in_view))
        else $error("pixel raised by a dropped point");

endmodule
